// ===== hdl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and codes of the pinned LRU block cache
// Command and status codes, fixed port widths and the control word that the
// sequencer sends along the row of cache cells.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int BLOCK_W    = 32;
    localparam int SLOT_OUT_W = 5;
    localparam int CFG_W      = 6;
    localparam int RANGE_W    = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Register index, taken from the word address of the APB port.
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

    typedef struct packed {
        logic look;       // capture match and candidate prefixes
        logic shift;      // move the selected entry to the top of the row
        logic dec;        // drop one pin of the selected entry in place
        logic use_match;  // select the matching entry, else the oldest candidate
    } t_cell_ctl;

endpackage

// ===== hdl/lbc_req_if.sv =====
// ----------------------------------------------------------------------------
// lbc_req_if: request channel of the block cache
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface lbc_req_if;
    logic                         valid;
    logic                         ready;
    logic [lbc_pkg::CMD_W-1:0]    cmd;
    logic [lbc_pkg::BLOCK_W-1:0]  block_id;
    logic                         last_in_range;

    modport source (output valid, cmd, block_id, last_in_range, input ready);
    modport sink   (input valid, cmd, block_id, last_in_range, output ready);
endinterface

// ===== hdl/lbc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lbc_rsp_if: response channel of the block cache
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface lbc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [lbc_pkg::STATUS_W-1:0]    status;
    logic                            hit;
    logic [lbc_pkg::SLOT_OUT_W-1:0]  slot;
    logic                            load_needed;
    logic                            evicted_valid;
    logic [lbc_pkg::BLOCK_W-1:0]     evicted_tag;
    logic                            was_loading;
    logic [lbc_pkg::RANGE_W-1:0]     range_loads;

    modport source (output valid, status, hit, slot, load_needed, evicted_valid,
                    evicted_tag, was_loading, range_loads, input ready);
    modport sink   (input valid, status, hit, slot, load_needed, evicted_valid,
                    evicted_tag, was_loading, range_loads, output ready);
endinterface

// ===== hdl/lbc_cell.sv =====
// ----------------------------------------------------------------------------
// lbc_cell: one position of the recency row
// Holds the slot at this recency position with its tag, pins and flags.
// Passes match and candidate prefixes upward and takes its upper neighbor's
// entry when the selected entry at or below it moves to the most recent position.
// ----------------------------------------------------------------------------
module lbc_cell #(
    parameter int SLOT_W     = 5,
    parameter int BLOCK_BITS = 32,
    parameter int PIN_BITS   = 8,
    parameter int LIM_W      = 6,
    parameter int RESET_SLOT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lbc_pkg::t_cell_ctl    i_ctl,
    input  logic [BLOCK_BITS-1:0] i_key,
    input  logic [LIM_W-1:0]      i_limit,
    input  logic                  i_pm_c,
    input  logic                  i_pc_c,
    input  logic                  i_pm_r,
    input  logic                  i_pc_r,
    input  logic [SLOT_W-1:0]     i_up_slot,
    input  logic [BLOCK_BITS-1:0] i_up_tag,
    input  logic                  i_up_valid,
    input  logic [PIN_BITS-1:0]   i_up_pin,
    input  logic                  i_up_ready,
    output logic                  o_pm_c,
    output logic                  o_pc_c,
    output logic                  o_pm_r,
    output logic                  o_pc_r,
    output logic [SLOT_W-1:0]     o_slot,
    output logic [BLOCK_BITS-1:0] o_tag,
    output logic                  o_valid,
    output logic [PIN_BITS-1:0]   o_pin,
    output logic                  o_ready,
    output logic                  o_sel
);

    logic [SLOT_W-1:0]     r_slot;
    logic [BLOCK_BITS-1:0] r_tag;
    logic                  r_valid;
    logic [PIN_BITS-1:0]   r_pin;
    logic                  r_ready;
    logic                  r_pm;
    logic                  r_pc;

    logic w_match;
    logic w_cand;
    logic w_sel;
    logic w_pref;
    logic w_load;

    assign w_match = r_valid && (r_tag == i_key);
    assign w_cand  = (r_pin == '0) && (LIM_W'(r_slot) < i_limit);

    assign o_pm_c = i_pm_c | w_match;
    assign o_pc_c = i_pc_c | w_cand;

    // The selected cell is the first one whose prefix rises.
    assign w_sel  = i_ctl.use_match ? (r_pm & ~i_pm_r) : (r_pc & ~i_pc_r);
    assign w_pref = i_ctl.use_match ? r_pm : r_pc;
    assign w_load = i_ctl.shift && w_pref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SLOT_W'(RESET_SLOT);
            r_valid <= 1'b0;
            r_pin   <= '0;
            r_ready <= 1'b1;
            r_pm    <= 1'b0;
            r_pc    <= 1'b0;
        end else begin
            if (i_ctl.look) begin
                r_pm <= o_pm_c;
                r_pc <= o_pc_c;
            end
            if (w_load) begin
                r_slot  <= i_up_slot;
                r_valid <= i_up_valid;
                r_pin   <= i_up_pin;
                r_ready <= i_up_ready;
            end else if (i_ctl.dec && w_sel && (r_pin != '0)) begin
                r_pin <= r_pin - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tag <= i_up_tag;
        end
    end

    assign o_pm_r  = r_pm;
    assign o_pc_r  = r_pc;
    assign o_slot  = r_slot;
    assign o_tag   = r_tag;
    assign o_valid = r_valid;
    assign o_pin   = r_pin;
    assign o_ready = r_ready;
    assign o_sel   = w_sel;

endmodule

// ===== hdl/lru_block_cache_with_pinning.sv =====
// Timing: an accepted request passes a look state and an apply state over
//   the cell row; its result is registered when the apply state completes,
//   later while the previous result has not been taken.
// Requests: a new one is taken only while idle or as the apply state ends.
// Reset: synchronous; all slots empty, unpinned and ready, recency in slot
//   order, range count zero, slots_in_use = SLOTS capped at 63.
// ----------------------------------------------------------------------------
// lru_block_cache_with_pinning: tag and replacement manager of a block cache
// A row of cells ordered from least to most recent holds the slots. Hits and
// victims are found by prefix chains along the row; a queued or fetched slot
// moves to the top, cells above it shift down by one; a freed one loses a pin in place.
// ----------------------------------------------------------------------------
module lru_block_cache_with_pinning #(
    parameter int SLOTS      = 32,
    parameter int BLOCK_BITS = 32,
    parameter int PIN_BITS   = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lbc_req_if.sink                         i_req,
    lbc_rsp_if.source                       o_rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lbc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lbc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lbc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int LIM_W     = $clog2(SLOTS + 1);
    localparam int CFG_RESET = (SLOTS > 63) ? 63 : SLOTS;
    localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOK  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [lbc_pkg::CFG_W-1:0]    r_cfg;
    logic [lbc_pkg::CMD_W-1:0]    r_cmd;
    logic [BLOCK_BITS-1:0]        r_key;
    logic                         r_last;
    logic [lbc_pkg::RANGE_W-1:0]  r_range;
    logic [lbc_pkg::RANGE_W-1:0]  n_range;

    logic                            r_out_valid;
    logic [lbc_pkg::STATUS_W-1:0]    r_status;
    logic                            r_hit;
    logic [lbc_pkg::SLOT_OUT_W-1:0]  r_slot;
    logic                            r_load;
    logic                            r_ev_valid;
    logic [lbc_pkg::BLOCK_W-1:0]     r_ev_block;
    logic                            r_was_loading;
    logic [lbc_pkg::RANGE_W-1:0]     r_range_loads;

    logic [lbc_pkg::STATUS_W-1:0]    n_status;
    logic                            n_hit;
    logic [lbc_pkg::SLOT_OUT_W-1:0]  n_slot;
    logic                            n_load;
    logic                            n_ev_valid;
    logic [lbc_pkg::BLOCK_W-1:0]     n_ev_block;
    logic                            n_was_loading;
    logic [lbc_pkg::RANGE_W-1:0]     n_range_loads;

    logic                w_accept;
    logic                w_apply_go;
    logic                w_cfg_wr;
    logic [LIM_W-1:0]    w_limit;
    logic                w_any_hit;
    logic                w_any_cand;
    lbc_pkg::t_cell_ctl  w_ctl;

    logic                  w_pm_c  [SLOTS];
    logic                  w_pc_c  [SLOTS];
    logic                  w_pm_r  [SLOTS];
    logic                  w_pc_r  [SLOTS];
    logic [SLOT_W-1:0]     w_slot  [SLOTS];
    logic [BLOCK_BITS-1:0] w_tag   [SLOTS];
    logic                  w_valid [SLOTS];
    logic [PIN_BITS-1:0]   w_pin   [SLOTS];
    logic                  w_ready [SLOTS];
    logic                  w_sel   [SLOTS];

    logic [SLOT_W-1:0]     g_slot;
    logic [BLOCK_BITS-1:0] g_tag;
    logic                  g_valid;
    logic [PIN_BITS-1:0]   g_pin;
    logic                  g_ready;

    logic [SLOT_W-1:0]     w_new_slot;
    logic [BLOCK_BITS-1:0] w_new_tag;
    logic                  w_new_valid;
    logic [PIN_BITS-1:0]   w_new_pin;
    logic                  w_new_ready;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == lbc_pkg::REG_SLOTS_IN_USE);
    assign prdata   = (paddr[2] == lbc_pkg::REG_SLOTS_IN_USE) ?
                      lbc_pkg::APB_DATA_W'(r_cfg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lbc_pkg::CFG_W'(CFG_RESET);
        end else if (w_cfg_wr) begin
            r_cfg <= pwdata[lbc_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            w_limit = LIM_W'(1);
        end else if (int'(r_cfg) > SLOTS) begin
            w_limit = LIM_W'(SLOTS);
        end else begin
            w_limit = LIM_W'(r_cfg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign w_apply_go  = (r_state == S_APPLY) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE) || w_apply_go;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_accept) n_state = S_LOOK;
                else if (w_apply_go) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_req.cmd;
            r_key  <= BLOCK_BITS'(i_req.block_id);
            r_last <= i_req.last_in_range;
        end
    end

    assign w_any_hit  = w_pm_r[SLOTS-1];
    assign w_any_cand = w_pc_r[SLOTS-1];

    always_comb begin
        w_ctl.look      = (r_state == S_LOOK);
        w_ctl.use_match = w_any_hit;
        w_ctl.shift     = 1'b0;
        w_ctl.dec       = 1'b0;
        if (w_apply_go) begin
            unique case (r_cmd)
                lbc_pkg::CMD_QUEUE: w_ctl.shift = w_any_hit || w_any_cand;
                lbc_pkg::CMD_GET:   w_ctl.shift = w_any_hit;
                lbc_pkg::CMD_FREE:  w_ctl.dec   = w_any_hit;
                default:            w_ctl.shift = 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Recency row, least recent at position 0
    // ------------------------------------------------------------------
    for (genvar p = 0; p < SLOTS; p++) begin : g_cell
        logic                  w_bpm_c;
        logic                  w_bpc_c;
        logic                  w_bpm_r;
        logic                  w_bpc_r;
        logic [SLOT_W-1:0]     w_up_slot;
        logic [BLOCK_BITS-1:0] w_up_tag;
        logic                  w_up_valid;
        logic [PIN_BITS-1:0]   w_up_pin;
        logic                  w_up_ready;

        if (p == 0) begin : g_bottom
            assign w_bpm_c = 1'b0;
            assign w_bpc_c = 1'b0;
            assign w_bpm_r = 1'b0;
            assign w_bpc_r = 1'b0;
        end else begin : g_inner
            assign w_bpm_c = w_pm_c[p-1];
            assign w_bpc_c = w_pc_c[p-1];
            assign w_bpm_r = w_pm_r[p-1];
            assign w_bpc_r = w_pc_r[p-1];
        end

        if (p == SLOTS - 1) begin : g_top
            assign w_up_slot  = w_new_slot;
            assign w_up_tag   = w_new_tag;
            assign w_up_valid = w_new_valid;
            assign w_up_pin   = w_new_pin;
            assign w_up_ready = w_new_ready;
        end else begin : g_below
            assign w_up_slot  = w_slot[p+1];
            assign w_up_tag   = w_tag[p+1];
            assign w_up_valid = w_valid[p+1];
            assign w_up_pin   = w_pin[p+1];
            assign w_up_ready = w_ready[p+1];
        end

        lbc_cell #(
            .SLOT_W     (SLOT_W),
            .BLOCK_BITS (BLOCK_BITS),
            .PIN_BITS   (PIN_BITS),
            .LIM_W      (LIM_W),
            .RESET_SLOT (p)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_limit    (w_limit),
            .i_pm_c     (w_bpm_c),
            .i_pc_c     (w_bpc_c),
            .i_pm_r     (w_bpm_r),
            .i_pc_r     (w_bpc_r),
            .i_up_slot  (w_up_slot),
            .i_up_tag   (w_up_tag),
            .i_up_valid (w_up_valid),
            .i_up_pin   (w_up_pin),
            .i_up_ready (w_up_ready),
            .o_pm_c     (w_pm_c[p]),
            .o_pc_c     (w_pc_c[p]),
            .o_pm_r     (w_pm_r[p]),
            .o_pc_r     (w_pc_r[p]),
            .o_slot     (w_slot[p]),
            .o_tag      (w_tag[p]),
            .o_valid    (w_valid[p]),
            .o_pin      (w_pin[p]),
            .o_ready    (w_ready[p]),
            .o_sel      (w_sel[p])
        );
    end

    // One-hot gather of the selected entry.
    always_comb begin
        g_slot  = '0;
        g_tag   = '0;
        g_valid = 1'b0;
        g_pin   = '0;
        g_ready = 1'b0;
        for (int p = 0; p < SLOTS; p++) begin
            g_slot  = g_slot  | (w_slot[p]  & {SLOT_W{w_sel[p]}});
            g_tag   = g_tag   | (w_tag[p]   & {BLOCK_BITS{w_sel[p]}});
            g_valid = g_valid | (w_valid[p] & w_sel[p]);
            g_pin   = g_pin   | (w_pin[p]   & {PIN_BITS{w_sel[p]}});
            g_ready = g_ready | (w_ready[p] & w_sel[p]);
        end
    end

    // Entry that lands at the most recent position.
    always_comb begin
        w_new_slot  = g_slot;
        w_new_valid = 1'b1;
        w_new_tag   = w_any_hit ? g_tag : r_key;
        w_new_pin   = g_pin;
        w_new_ready = 1'b1;
        if (r_cmd == lbc_pkg::CMD_QUEUE) begin
            w_new_pin   = (g_pin == PIN_MAX) ? g_pin : g_pin + 1'b1;
            w_new_ready = w_any_hit ? g_ready : 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result and range count
    // ------------------------------------------------------------------
    always_comb begin
        n_status      = lbc_pkg::ST_OK;
        n_hit         = 1'b0;
        n_slot        = '0;
        n_load        = 1'b0;
        n_ev_valid    = 1'b0;
        n_ev_block    = '0;
        n_was_loading = 1'b0;
        n_range_loads = '0;
        n_range       = r_range;
        unique case (r_cmd)
            lbc_pkg::CMD_QUEUE: begin
                if (w_any_hit) begin
                    n_hit  = 1'b1;
                    n_slot = lbc_pkg::SLOT_OUT_W'(g_slot);
                end else if (w_any_cand) begin
                    n_load     = 1'b1;
                    n_slot     = lbc_pkg::SLOT_OUT_W'(g_slot);
                    n_ev_valid = g_valid;
                    n_ev_block = g_valid ? lbc_pkg::BLOCK_W'(g_tag) : '0;
                    if (r_range != lbc_pkg::RANGE_MAX) n_range = r_range + 1'b1;
                end else begin
                    n_status = lbc_pkg::ST_NO_SLOT;
                end
                if (r_last) begin
                    n_range_loads = n_range;
                    n_range       = '0;
                end
            end
            lbc_pkg::CMD_GET, lbc_pkg::CMD_FREE: begin
                if (w_any_hit) begin
                    n_hit         = 1'b1;
                    n_slot        = lbc_pkg::SLOT_OUT_W'(g_slot);
                    n_was_loading = (r_cmd == lbc_pkg::CMD_GET) && !g_ready;
                end else begin
                    n_status = lbc_pkg::ST_MISSING;
                end
            end
            default: begin
                n_status = lbc_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_apply_go) begin
            r_range     <= n_range;
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply_go) begin
            r_status      <= n_status;
            r_hit         <= n_hit;
            r_slot        <= n_slot;
            r_load        <= n_load;
            r_ev_valid    <= n_ev_valid;
            r_ev_block    <= n_ev_block;
            r_was_loading <= n_was_loading;
            r_range_loads <= n_range_loads;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.slot          = r_slot;
    assign o_rsp.load_needed   = r_load;
    assign o_rsp.evicted_valid = r_ev_valid;
    assign o_rsp.evicted_tag   = r_ev_block;
    assign o_rsp.was_loading   = r_was_loading;
    assign o_rsp.range_loads   = r_range_loads;

endmodule

// ===== hdl/lbc_checker.sv =====
// ----------------------------------------------------------------------------
// lbc_checker: port-level checks of the block cache
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module lbc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [lbc_pkg::STATUS_W-1:0]    i_rsp_status,
    input logic                            i_rsp_hit,
    input logic [lbc_pkg::SLOT_OUT_W-1:0]  i_rsp_slot,
    input logic                            i_rsp_load,
    input logic                            i_rsp_ev_valid,
    input logic                            i_rsp_was_loading
);

    // A stalled result beat keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
        $stable(i_rsp_slot) && $stable(i_rsp_hit))
        else $error("response beat changed while stalled");

    // A new request is refused while the previous lookup is running.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while the previous lookup was running");

    // A failed request reports no slot, hit or load.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != lbc_pkg::ST_OK) |->
        !i_rsp_hit && (i_rsp_slot == '0) && !i_rsp_load && !i_rsp_was_loading)
        else $error("failed request carries result fields");

    // Loads happen only on misses, and evictions only with a load.
    a_load_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_load || i_rsp_ev_valid) |->
        i_rsp_load && !i_rsp_hit && !i_rsp_was_loading)
        else $error("load or eviction reported on a hit");

endmodule

bind lru_block_cache_with_pinning lbc_checker u_lbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_hit         (o_rsp.hit),
    .i_rsp_slot        (o_rsp.slot),
    .i_rsp_load        (o_rsp.load_needed),
    .i_rsp_ev_valid    (o_rsp.evicted_valid),
    .i_rsp_was_loading (o_rsp.was_loading)
);
